// File: rtl/assert_macros.svh
// Shared assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: rtl/b64ud_pkg.sv
package b64ud_pkg;

    localparam int CHAR_W      = 8;
    localparam int BYTE_W      = 8;
    localparam int SEXTET_W    = 6;
    localparam int CAP_W       = 24;
    localparam int BW_W        = 24;
    localparam int COUNT_W_DEF = 24;

    localparam logic [CAP_W-1:0]  CAP_RESET = 24'hFF_FFFF;
    localparam logic [CHAR_W-1:0] PAD_CHAR  = 8'h2E;

    localparam logic REQ_CHAR   = 1'b0;
    localparam logic REQ_END    = 1'b1;
    localparam logic RES_DATA   = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    typedef enum logic [2:0] {
        PAD_NONE = 3'b001,
        PAD_HALF = 3'b010,
        PAD_DONE = 3'b100
    } pad_state_t;

    typedef struct packed {
        logic              req_type;
        logic [CHAR_W-1:0] char_code;
    } in_item_t;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] data_byte;
        logic              decode_ok;
        logic [BW_W-1:0]   bytes_written;
    } out_item_t;

    typedef struct packed {
        logic                bad;
        logic [SEXTET_W-1:0] value;
    } sextet_t;

    // Map one character of the URL-safe alphabet to its sextet; flag others.
    function automatic sextet_t sextet_lookup(input logic [CHAR_W-1:0] c);
        sextet_t r;
        r.bad   = 1'b0;
        r.value = '0;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r.value = SEXTET_W'(c - 8'h41);
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            r.value = SEXTET_W'(c - 8'h61 + 8'd26);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            r.value = SEXTET_W'(c - 8'h30 + 8'd52);
        end else if (c == 8'h2D) begin
            r.value = 6'd62;
        end else if (c == 8'h5F) begin
            r.value = 6'd63;
        end else begin
            r.bad = 1'b1;
        end
        return r;
    endfunction

endpackage

// File: rtl/base64url_dot_pad_decoder.sv
// An accepted item is decoded from the input register; its result goes to the result register.
// One item per cycle while out_stall is low; the decode path limits nothing below that.
// Items with no result (first sextet, pads, errors, dropped bytes) still use the input stage.
// Reset (rst_n low, asynchronous): group, padding, error and byte count state clear,
// out_capacity returns to 0xFFFFFF, both pipeline registers empty.
`include "assert_macros.svh"

module base64url_dot_pad_decoder #(
    parameter int COUNT_WIDTH = b64ud_pkg::COUNT_W_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input item channel
    input  logic                           in_valid,
    output logic                           in_stall,
    input  b64ud_pkg::in_item_t            in_item,
    // result item channel
    output logic                           out_valid,
    input  logic                           out_stall,
    output b64ud_pkg::out_item_t           out_item,
    // out_capacity write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [b64ud_pkg::CAP_W-1:0]    cfg_data
);

    // Compare width wide enough for both the count and the capacity.
    localparam int CMP_W = (COUNT_WIDTH > b64ud_pkg::CAP_W) ? COUNT_WIDTH : b64ud_pkg::CAP_W;

    // Input register: holds the item being decoded this cycle.
    logic                  s1_valid_reg, s1_valid_next;
    b64ud_pkg::in_item_t   s1_item_reg;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    b64ud_pkg::out_item_t  out_item_reg;

    // Decoder state.
    logic [1:0]                       group_pos_reg, group_pos_next;
    logic [b64ud_pkg::SEXTET_W-1:0]   prev_sextet_reg, prev_sextet_next;
    b64ud_pkg::pad_state_t            pad_state_reg, pad_state_next;
    logic                             failed_reg, failed_next;
    logic [COUNT_WIDTH-1:0]           byte_count_reg, byte_count_next;
    logic [b64ud_pkg::CAP_W-1:0]      cap_reg;

    logic                  adv;        // result register free or being emptied
    logic                  accept;     // input item taken this edge
    logic                  s1_fire;    // held item is decoded this edge
    logic                  emit;
    b64ud_pkg::out_item_t  res;
    b64ud_pkg::sextet_t    sx;
    logic                  is_pad;
    logic [b64ud_pkg::BYTE_W-1:0] dbyte;
    logic [CMP_W-1:0]      cnt_ext;
    logic [CMP_W-1:0]      cap_ext;
    logic                  room;

    // The decode step never waits on anything but the result register.
    assign adv      = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !adv;
    assign accept   = in_valid && !in_stall;
    assign s1_fire  = s1_valid_reg && adv;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // Users must change capacity only while idle; the block doesn't enforce it, taking every write.
    assign cfg_ready = 1'b1;

    assign sx      = b64ud_pkg::sextet_lookup(s1_item_reg.char_code);
    assign is_pad  = (s1_item_reg.char_code == b64ud_pkg::PAD_CHAR);
    assign cnt_ext = CMP_W'(byte_count_reg);
    assign cap_ext = CMP_W'(cap_reg);
    // A byte goes out only while the count is below capacity and not saturated.
    assign room    = (cnt_ext < cap_ext) && (byte_count_reg != {COUNT_WIDTH{1'b1}});

    // Assemble the byte from the previous sextet and the current one.
    always_comb
    begin
        case (group_pos_reg)
            2'd1:    dbyte = {prev_sextet_reg, sx.value[5:4]};
            2'd2:    dbyte = {prev_sextet_reg[3:0], sx.value[5:2]};
            2'd3:    dbyte = {prev_sextet_reg[1:0], sx.value};
            default: dbyte = '0;
        endcase
    end

    // Single decode step on the held item.
    always_comb
    begin
        group_pos_next   = group_pos_reg;
        prev_sextet_next = prev_sextet_reg;
        pad_state_next   = pad_state_reg;
        failed_next      = failed_reg;
        byte_count_next  = byte_count_reg;
        emit             = 1'b0;
        res              = '0;

        if (s1_fire) begin
            if (s1_item_reg.req_type == b64ud_pkg::REQ_END) begin
                // Report status, then drop back to the start of a message.
                emit               = 1'b1;
                res.result_kind    = b64ud_pkg::RES_STATUS;
                res.decode_ok      = !failed_reg && (group_pos_reg == 2'd0);
                res.bytes_written  = cnt_ext[b64ud_pkg::BW_W-1:0];
                group_pos_next     = '0;
                prev_sextet_next   = '0;
                pad_state_next     = b64ud_pkg::PAD_NONE;
                failed_next        = 1'b0;
                byte_count_next    = '0;
            end else if (!failed_reg) begin
                case (pad_state_reg)
                    b64ud_pkg::PAD_DONE:
                    begin
                        // Nothing may follow complete padding.
                        failed_next = 1'b1;
                    end
                    b64ud_pkg::PAD_HALF:
                    begin
                        if (is_pad) begin
                            pad_state_next = b64ud_pkg::PAD_DONE;
                            group_pos_next = 2'd0;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    b64ud_pkg::PAD_NONE:
                    begin
                        if (is_pad) begin
                            if (group_pos_reg == 2'd2) begin
                                pad_state_next = b64ud_pkg::PAD_HALF;
                                group_pos_next = 2'd3;
                            end else if (group_pos_reg == 2'd3) begin
                                pad_state_next = b64ud_pkg::PAD_DONE;
                                group_pos_next = 2'd0;
                            end else begin
                                failed_next = 1'b1;
                            end
                        end else if (sx.bad) begin
                            failed_next = 1'b1;
                        end else begin
                            group_pos_next   = group_pos_reg + 2'd1;
                            prev_sextet_next = sx.value;
                            if (group_pos_reg != 2'd0 && room) begin
                                emit            = 1'b1;
                                res.result_kind = b64ud_pkg::RES_DATA;
                                res.data_byte   = dbyte;
                                byte_count_next = byte_count_reg + COUNT_WIDTH'(1);
                            end
                        end
                    end
                    default:
                    begin
                        failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

    // Input register: load on accept, empty once decoded.
    always_comb
    begin
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    // Result register: refill whenever it advances.
    always_comb
    begin
        if (adv) begin
            out_valid_next = emit;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            group_pos_reg   <= '0;
            prev_sextet_reg <= '0;
            pad_state_reg   <= b64ud_pkg::PAD_NONE;
            failed_reg      <= 1'b0;
            byte_count_reg  <= '0;
            cap_reg         <= b64ud_pkg::CAP_RESET;
        end else begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            group_pos_reg   <= group_pos_next;
            prev_sextet_reg <= prev_sextet_next;
            pad_state_reg   <= pad_state_next;
            failed_reg      <= failed_next;
            byte_count_reg  <= byte_count_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Payload registers: hold unless loaded.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            s1_item_reg <= in_item;
        end
        if (adv && emit) begin
            out_item_reg <= res;
        end
    end

    `ASSERT_CLK(a_half_pad_pos, clk, rst_n, (pad_state_reg == b64ud_pkg::PAD_HALF) |-> (group_pos_reg == 2'd3), "pending pad outside group position 3")
    `ASSERT_CLK(a_done_pad_pos, clk, rst_n, (pad_state_reg == b64ud_pkg::PAD_DONE) |-> (group_pos_reg == 2'd0), "complete padding not at group start")
    `ASSERT_CLK(a_end_clears, clk, rst_n, (s1_fire && s1_item_reg.req_type == b64ud_pkg::REQ_END) |=> (group_pos_reg == 2'd0 && !failed_reg && byte_count_reg == '0), "end item did not clear state")
    `ASSERT_CLK(a_count_step, clk, rst_n, (emit && res.result_kind == b64ud_pkg::RES_DATA) |=> (byte_count_reg == $past(byte_count_reg) + COUNT_WIDTH'(1)), "data byte without count step")

endmodule

// File: bench/testbench.sv
module testbench;
    import b64ud_pkg::*;

    // The block shows a result after the item passes its input and result registers; give it
    // some slack before a register write or the final check.
    localparam int LATENCY     = 2;
    localparam int SETTLE      = LATENCY + 4;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 180;
    localparam int NUM_PHASES  = 5;
    localparam int SHOW_LIMIT  = 10;
    localparam logic [COUNT_W_DEF-1:0] COUNT_SAT = '1;

    // One entry of the character feed: either an item for the block or a request
    // to hold the feed until every pending decode has come back.
    typedef struct {
        bit       pause;
        in_item_t item;
    } feed_entry_t;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    in_item_t         in_item   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    out_item_t        out_item;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CAP_W-1:0] cfg_data  = '0;

    feed_entry_t char_feed[$];
    out_item_t   expected_decodes[$];

    // Decoder state as the bench sees it, plus the current out_capacity.
    logic [1:0]             grp_pos;
    logic [SEXTET_W-1:0]    last_sextet;
    pad_state_t             pad_phase;
    bit                     msg_failed;
    logic [COUNT_W_DEF-1:0] delivered;
    logic [CAP_W-1:0]       capacity;

    int mismatches  = 0;
    int cycle_count = 0;

    // Sender burst shaping and the hold requested by a pause entry.
    int burst_left = 0;
    int gap_left   = 0;
    bit draining   = 1'b0;
    feed_entry_t next_entry;

    // Receiver stall pattern: a mode held for a random stretch of cycles.
    int stall_mode = 0;
    int stall_left = 0;
    out_item_t want;

    base64url_dot_pad_decoder uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Sextet of a URL-safe character, or -1 for anything outside the alphabet.
    function automatic int sextet_value(input logic [CHAR_W-1:0] c);
        if (c >= "A" && c <= "Z")
            return int'(c) - int'("A");
        if (c >= "a" && c <= "z")
            return int'(c) - int'("a") + 26;
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0") + 52;
        if (c == "-")
            return 62;
        if (c == "_")
            return 63;
        return -1;
    endfunction

    // Character that encodes sextet v.
    function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
        if (v < 26)
            return CHAR_W'("A" + v);
        if (v < 52)
            return CHAR_W'("a" + v - 26);
        if (v < 62)
            return CHAR_W'("0" + v - 52);
        return (v == 62) ? CHAR_W'("-") : CHAR_W'("_");
    endfunction

    function automatic logic [CHAR_W-1:0] rand_alpha();
        return sextet_char(SEXTET_W'($urandom_range(0, 63)));
    endfunction

    task automatic clear_decoder();
        grp_pos     = 2'd0;
        last_sextet = '0;
        pad_phase   = PAD_NONE;
        msg_failed  = 1'b0;
        delivered   = '0;
    endtask

    // Advance the decoder state by one accepted item and queue the result it causes.
    task automatic decode_char_item(input in_item_t it);
        out_item_t         res;
        int                sx;
        logic [SEXTET_W-1:0] cur;
        logic [BYTE_W-1:0] dbyte;
        res   = '0;
        dbyte = '0;
        if (it.req_type == REQ_END) begin
            // End of message: report status and count, then start over.
            res.result_kind   = RES_STATUS;
            res.decode_ok     = !msg_failed && grp_pos == 2'd0;
            res.bytes_written = BW_W'(delivered);
            expected_decodes.push_back(res);
            clear_decoder();
        end else if (msg_failed) begin
            // Drop characters until the end item.
        end else if (pad_phase == PAD_DONE) begin
            // Anything after complete padding is trailing data.
            msg_failed = 1'b1;
        end else if (pad_phase == PAD_HALF) begin
            // The second pad of a two-pad group must follow.
            if (it.char_code == PAD_CHAR) begin
                pad_phase = PAD_DONE;
                grp_pos   = 2'd0;
            end else begin
                msg_failed = 1'b1;
            end
        end else if (it.char_code == PAD_CHAR) begin
            if (grp_pos == 2'd2) begin
                pad_phase = PAD_HALF;
                grp_pos   = 2'd3;
            end else if (grp_pos == 2'd3) begin
                pad_phase = PAD_DONE;
                grp_pos   = 2'd0;
            end else begin
                msg_failed = 1'b1;
            end
        end else begin
            sx = sextet_value(it.char_code);
            if (sx < 0) begin
                msg_failed = 1'b1;
            end else begin
                cur = SEXTET_W'(sx);
                case (grp_pos)
                    2'd1:    dbyte = {last_sextet, cur[5:4]};
                    2'd2:    dbyte = {last_sextet[3:0], cur[5:2]};
                    2'd3:    dbyte = {last_sextet[1:0], cur};
                    default: dbyte = '0;
                endcase
                // Deliver only while below the capacity and below counter saturation.
                if (grp_pos != 2'd0 && delivered < capacity && delivered != COUNT_SAT) begin
                    delivered       = delivered + 1'b1;
                    res.result_kind = RES_DATA;
                    res.data_byte   = dbyte;
                    expected_decodes.push_back(res);
                end
                last_sextet = cur;
                grp_pos     = grp_pos + 2'd1;
            end
        end
    endtask

    task automatic feed_char(input logic [CHAR_W-1:0] c);
        feed_entry_t e;
        e.pause          = 1'b0;
        e.item.req_type  = REQ_CHAR;
        e.item.char_code = c;
        char_feed.push_back(e);
    endtask

    // The character field of an end item is ignored; fill it with noise anyway.
    task automatic feed_end();
        feed_entry_t e;
        e.pause          = 1'b0;
        e.item.req_type  = REQ_END;
        e.item.char_code = CHAR_W'($urandom_range(0, 255));
        char_feed.push_back(e);
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            feed_char(s[i]);
    endtask

    // Build one message: mostly well-formed groups with random content and an optional
    // padded tail, sometimes broken on purpose. Return the number of items queued.
    task automatic feed_message(output int n);
        logic [CHAR_W-1:0] text[$];
        int groups;
        int tail;
        int flaw;
        int at;
        groups = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 24) : $urandom_range(0, 4);
        for (int i = 0; i < groups * 4; i++)
            text.push_back(rand_alpha());
        tail = $urandom_range(0, 2);
        if (tail == 1) begin
            text.push_back(rand_alpha());
            text.push_back(rand_alpha());
            text.push_back(PAD_CHAR);
            text.push_back(PAD_CHAR);
        end else if (tail == 2) begin
            text.push_back(rand_alpha());
            text.push_back(rand_alpha());
            text.push_back(rand_alpha());
            text.push_back(PAD_CHAR);
        end
        flaw = $urandom_range(0, 11);
        at   = $urandom_range(0, text.size());
        case (flaw)
            // stray byte of any value somewhere in the message
            0: text.insert(at, CHAR_W'($urandom_range(0, 255)));
            // pad dropped at a random spot, often in an illegal position
            1: text.insert(at, PAD_CHAR);
            // cut the message short: end inside a group or inside padding
            2: if (text.size() != 0) text.delete(text.size() - 1);
            // trailing character after the last group or after padding
            3: text.push_back(rand_alpha());
            // second pad replaced by data
            4: if (tail == 1) text[text.size() - 1] = rand_alpha();
            // a short run of raw noise bytes
            5: repeat ($urandom_range(1, 4)) text.push_back(CHAR_W'($urandom_range(0, 255)));
            default: ;
        endcase
        foreach (text[i])
            feed_char(text[i]);
        feed_end();
        n = text.size() + 1;
    endtask

    task automatic queue_pause();
        feed_entry_t e;
        e.pause = 1'b1;
        e.item  = '0;
        char_feed.push_back(e);
    endtask

    // Hold until the feed is empty, the sender is quiet and every decode is back,
    // then let the pipeline drain items that cause no result.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (char_feed.size() != 0 || in_valid || draining || expected_decodes.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        capacity = value;
        cfg_valid <= 1'b0;
    endtask

    // Sender: take the accepted item into the decoder state, then pick the next one.
    // Items go out in bursts of random length with random gaps between them.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                decode_char_item(in_item);
            // A stalled item stays on the wires unchanged.
            if (!(in_valid && in_stall)) begin
                if (draining) begin
                    if (expected_decodes.size() == 0)
                        draining = 1'b0;
                    in_valid <= 1'b0;
                end else if (gap_left != 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (char_feed.size() != 0) begin
                    next_entry = char_feed.pop_front();
                    if (next_entry.pause) begin
                        draining = 1'b1;
                        in_valid <= 1'b0;
                    end else begin
                        in_item  <= next_entry.item;
                        in_valid <= 1'b1;
                        if (burst_left == 0) begin
                            // Now and then a long run with no idle cycles at all.
                            burst_left = ($urandom_range(0, 7) == 0) ?
                                         $urandom_range(100, 250) : $urandom_range(1, 24);
                            gap_left   = $urandom_range(1, 6);
                        end else begin
                            burst_left--;
                        end
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted result against the oldest pending decode,
    // then choose the stall for the next cycle from the current mode.
    always @(posedge clk)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_decodes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("cycle %0d: unexpected result kind %0d byte %02h ok %0d count %0d",
                                 cycle_count, out_item.result_kind, out_item.data_byte,
                                 out_item.decode_ok, out_item.bytes_written);
                end else begin
                    want = expected_decodes.pop_front();
                    if (out_item.result_kind !== want.result_kind ||
                        out_item.data_byte !== want.data_byte ||
                        out_item.decode_ok !== want.decode_ok ||
                        out_item.bytes_written !== want.bytes_written) begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT)
                            $display({"cycle %0d: expected kind %0d byte %02h ok %0d count %0d,",
                                      " got kind %0d byte %02h ok %0d count %0d"},
                                     cycle_count, want.result_kind, want.data_byte,
                                     want.decode_ok, want.bytes_written,
                                     out_item.result_kind, out_item.data_byte,
                                     out_item.decode_ok, out_item.bytes_written);
                    end
                end
            end
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(16, 160);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= stall_left[2];
            endcase
        end
    end

    // Guard against a hang anywhere in the run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        int fed;
        int got;
        bit paused;
        logic [CAP_W-1:0] cap;
        clear_decoder();
        capacity = CAP_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed messages at the reset capacity.
        feed_end();                          // empty message is valid
        feed_text("_-9z");                   // alphabet extremes, one full group
        feed_end();
        feed_text("QQ..");                   // pad at position 2, then the second pad
        feed_end();
        feed_text("QUI.A");                  // pad at position 3, then trailing data
        feed_end();
        feed_char(8'hFF);                    // character outside the alphabet
        feed_end();
        feed_text("QQ.A");                   // second pad replaced by data
        feed_end();
        feed_text("Q.");                     // pad at position 1
        feed_end();
        wait_idle();

        // Random messages under several capacities: none, one byte, a few, the
        // full range and an arbitrary value.
        paused = 1'b0;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       cap = '0;
                1:       cap = CAP_W'(1);
                2:       cap = CAP_W'($urandom_range(2, 12));
                3:       cap = CAP_RESET;
                default: cap = CAP_W'($urandom);
            endcase
            write_capacity(cap);
            fed = 0;
            while (fed < PHASE_ITEMS) begin
                feed_message(got);
                fed += got;
                // Once, halfway through phase 2, hold the sender until all decodes are in.
                if (ph == 2 && !paused && fed > PHASE_ITEMS / 2) begin
                    queue_pause();
                    paused = 1'b1;
                end
            end
            wait_idle();
        end

        if (expected_decodes.size() != 0) begin
            mismatches += expected_decodes.size();
            $display("%0d decodes never arrived", expected_decodes.size());
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
